// ===== rtl/core/b64d_pkg.sv =====
// Package for the base64 stream decoder: payload structs, status codes,
// the group record passed from front to back, and the character classifier.
// Depends on nothing; every module of the decoder imports it.
`default_nettype none

package b64d_pkg;

    // Width of the saturating character and pad-run counters.
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Depth of the record queue between the front and the back.
    localparam int Q_DEPTH     = 4;
    localparam int Q_ADDR_BITS = $clog2(Q_DEPTH);

    // Characters that the classifier singles out.
    localparam logic [7:0] CH_PAD   = 8'h3D; // '='
    localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CH_SLASH = 8'h2F; // '/'

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LENGTH  = 2'd2,
        ST_ILLEGAL = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } char_req_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        status_t    status;
        logic       run_end;
    } dec_result_t;

    // One record holds everything a single accepted character produces:
    // up to three bytes of a closed group and, on the last character, a status.
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  nbytes;
        logic        fin;
        status_t     status;
    } group_rec_t;

    typedef struct packed {
        logic       pad;
        logic       bad;
        logic [5:0] sx;
    } char_class_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = '{pad: 1'b0, bad: 1'b0, sx: 6'd0};
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.sx = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.sx = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r.sx = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == CH_PLUS)
        begin
            r.sx = 6'd62;
        end
        else if (c == CH_SLASH)
        begin
            r.sx = 6'd63;
        end
        else if (c == CH_PAD)
        begin
            r.pad = 1'b1;
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// Top level of the base64 stream decoder: front, record queue and back.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//   Channel    Handshake          Payload          Direction
//   request    push / full        char_req_t       into the block
//   result     empty / pop        dec_result_t     out of the block
//
// One character request is taken in every cycle while the record queue has room.
// A character that closes a group or ends the string leaves one record that the
// back part turns into one to four results, one per cycle, so the result port
// sets the sustained rate when groups close faster than results are popped.
// Reset clears all string state, the queue and the result valid flag.
// The front stalls only on a full queue; the back stalls only while its result is not popped.
`default_nettype none

module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire char_req_t   char_req,
    output logic             empty,
    input  wire logic        pop,
    output dec_result_t      dec_result
);

    // Records move from the front into the queue and from the queue to the back.
    logic       q_push;
    logic       q_full;
    group_rec_t q_wr_rec;
    logic       q_pop;
    logic       q_empty;
    group_rec_t q_rd_rec;

    // The front classifies each request and updates the string state.
    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .char_req (char_req),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_wr_rec)
    );

    // The queue holds up to four records, each up to three bytes plus a status.
    b64d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_rec),
        .q_empty (q_empty)
    );

    // The back serializes each record into results.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_rec),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .dec_result (dec_result)
    );

`ifndef SYNTH
    // The front must never write a record into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("record pushed into full queue");

    // A data byte result never carries a status or an end mark.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !dec_result.is_status) |->
            (dec_result.status == ST_OK && !dec_result.run_end))
        else $error("data result carries status fields");

    // A status result carries the end mark and a zero byte.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dec_result.is_status) |->
            (dec_result.run_end && dec_result.data_byte == 8'd0))
        else $error("status result malformed");

    // The last character of a string always leads to a waiting result.
    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && char_req.final_char) |-> ##2 !empty)
        else $error("no result after last character");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// Front part of the base64 decoder: classifies each character, tracks the
// open group and string state, and emits one group record per useful character.
// Depends on b64d_pkg.
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire char_req_t  char_req,
    input  wire logic       q_full,
    output logic            q_push,
    output group_rec_t      q_rec
);

    logic [17:0]           accum_reg, accum_next;
    logic [1:0]            slot_reg, slot_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] pad_run_reg, pad_run_next;
    logic [1:0]            pad_in_reg, pad_in_next;
    logic                  illegal_reg, illegal_next;

    char_class_t           cls;
    logic [5:0]            sx;
    logic [23:0]           group;
    logic [1:0]            nbytes;
    logic [1:0]            pad_in_upd;
    logic [COUNT_BITS-1:0] quarter;
    logic [COUNT_BITS-1:0] full_len;
    status_t               status;
    logic                  accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign cls    = classify(char_req.char_code);
    assign sx     = (cls.pad || cls.bad) ? 6'd0 : cls.sx;
    assign group  = {accum_reg, sx};

    always_comb
    begin
        illegal_next = illegal_reg;
        pad_in_upd   = pad_in_reg;
        pad_run_next = pad_run_reg;
        if (cls.pad)
        begin
            if (slot_reg < 2'd2)
            begin
                illegal_next = 1'b1;
            end
            else
            begin
                pad_in_upd = pad_in_reg + 2'd1;
            end
            if (pad_run_reg != COUNT_MAX)
            begin
                pad_run_next = pad_run_reg + 1'b1;
            end
        end
        else
        begin
            if (pad_run_reg != '0 || cls.bad)
            begin
                illegal_next = 1'b1;
            end
            pad_run_next = '0;
        end

        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        if (slot_reg == 2'd3)
        begin
            nbytes      = (pad_in_upd >= 2'd2) ? 2'd1 : 2'd3 - pad_in_upd;
            accum_next  = '0;
            pad_in_next = '0;
            slot_next   = 2'd0;
        end
        else
        begin
            nbytes      = 2'd0;
            accum_next  = group[17:0];
            pad_in_next = pad_in_upd;
            slot_next   = slot_reg + 2'd1;
        end

        // The full output length never exceeds the counter width.
        quarter  = count_next >> 2;
        full_len = COUNT_BITS'((quarter << 1) + quarter);

        if (count_next == '0 || full_len <= pad_run_next)
        begin
            status = ST_INVALID;
        end
        else if (slot_next != 2'd0)
        begin
            status = ST_LENGTH;
        end
        else if (illegal_next)
        begin
            status = ST_ILLEGAL;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign q_rec  = '{group: group, nbytes: nbytes, fin: char_req.final_char,
                      status: status};
    assign q_push = accept && (nbytes != 2'd0 || char_req.final_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg   <= '0;
            slot_reg    <= '0;
            count_reg   <= '0;
            pad_run_reg <= '0;
            pad_in_reg  <= '0;
            illegal_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (char_req.final_char)
            begin
                accum_reg   <= '0;
                slot_reg    <= '0;
                count_reg   <= '0;
                pad_run_reg <= '0;
                pad_in_reg  <= '0;
                illegal_reg <= 1'b0;
            end
            else
            begin
                accum_reg   <= accum_next;
                slot_reg    <= slot_next;
                count_reg   <= count_next;
                pad_run_reg <= pad_run_next;
                pad_in_reg  <= pad_in_next;
                illegal_reg <= illegal_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
// Short record queue that decouples the decoder front from its back.
// Depends on b64d_pkg for the record type and depth.
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire group_rec_t wr_data,
    output logic            q_full,
    input  wire logic       rd_en,
    output group_rec_t      rd_data,
    output logic            q_empty
);

    group_rec_t             mem_reg [Q_DEPTH];
    logic [Q_ADDR_BITS-1:0] wr_ptr_reg;
    logic [Q_ADDR_BITS-1:0] rd_ptr_reg;
    logic [Q_ADDR_BITS:0]   count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign q_full  = (count_reg == (Q_ADDR_BITS+1)'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_ADDR_BITS'(Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_ADDR_BITS'(Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// Back part of the base64 decoder: holds one group record and hands out its
// bytes and closing status one result at a time. Depends on b64d_pkg.
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire group_rec_t q_data,
    output logic            q_pop,
    output logic            empty,
    input  wire logic       pop,
    output dec_result_t     dec_result
);

    group_rec_t  cur_reg;
    logic        valid_reg;
    logic [1:0]  pos_reg;
    logic [2:0]  total;
    logic        last;
    logic        take;
    logic        load;
    logic [7:0]  byte_sel;

    assign total = {1'b0, cur_reg.nbytes} + {2'b00, cur_reg.fin};
    assign last  = ({1'b0, pos_reg} + 3'd1) == total;
    assign take  = pop && valid_reg;
    assign load  = !valid_reg || (take && last);
    assign q_pop = load && !q_empty;
    assign empty = !valid_reg;

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    byte_sel = cur_reg.group[23:16];
            2'd1:    byte_sel = cur_reg.group[15:8];
            default: byte_sel = cur_reg.group[7:0];
        endcase
        if (pos_reg < cur_reg.nbytes)
        begin
            dec_result = '{is_status: 1'b0, data_byte: byte_sel, status: ST_OK,
                           run_end: 1'b0};
        end
        else
        begin
            dec_result = '{is_status: 1'b1, data_byte: 8'd0, status: cur_reg.status,
                           run_end: 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire
